### hw/rtl/lobm_pkg.sv
`default_nettype none
package lobm_pkg;

    localparam int PRICE_LEVELS = 256;
    localparam int PRICE_W      = $clog2(PRICE_LEVELS);
    localparam int LVL_ADDR_W   = PRICE_W + 1;
    localparam int ORDER_SLOTS  = 64;
    localparam int SLOT_W       = 6;
    localparam int CNT_W        = 7;
    localparam int MAX_RESULTS  = 64;
    localparam int TB_AW        = 6;
    localparam int ID_W         = 32;
    localparam int QTY_W        = 16;
    localparam int TOTAL_W      = 22;
    localparam int SUM_W        = 23;
    localparam int CHUNK_BITS   = 4;
    localparam int CHUNK_W      = 1 << CHUNK_BITS;
    localparam int CHUNK_IDX_W  = PRICE_W - CHUNK_BITS;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef enum logic [1:0] {
        TIF_GTC,
        TIF_IOC,
        TIF_FOK,
        TIF_DTC
    } tif_t;

    typedef enum logic [1:0] {
        STATUS_NOT_RESTED,
        STATUS_RESTED,
        STATUS_FULL,
        STATUS_FOK_KILLED
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FOK_START,
        S_FOK_CHK,
        S_FOK_ADD,
        S_FOK_SCAN,
        S_M_TOP,
        S_M_LVL,
        S_M_SLOT,
        S_M_SCAN,
        S_REST,
        S_R_POP,
        S_R_WR,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    typedef struct packed {
        logic               start;
        logic               side;
        logic [PRICE_W-1:0] from;
    } scan_req_t;

    typedef struct packed {
        logic               done;
        logic               found;
        logic [PRICE_W-1:0] index;
    } scan_rsp_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [SLOT_W-1:0]  head;
        logic [SLOT_W-1:0]  tail;
    } level_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [QTY_W-1:0] rem;
    } slot_t;

    typedef struct packed {
        logic [ID_W-1:0]    rid;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } trade_t;

    typedef struct packed {
        logic [ID_W-1:0]    aggressor_id;
        logic [ID_W-1:0]    resting_id;
        logic [PRICE_W-1:0] trade_price;
        logic [QTY_W-1:0]   trade_qty;
        logic               last;
        logic [1:0]         status;
        logic [PRICE_W-1:0] best_bid;
        logic               best_bid_valid;
        logic [PRICE_W-1:0] best_ask;
        logic               best_ask_valid;
        logic [CNT_W-1:0]   resting_count;
    } result_t;

    function automatic logic crosses(input logic side, input logic mkt,
                                     input logic [PRICE_W-1:0] limit,
                                     input logic [PRICE_W-1:0] lvl);
        logic c;
        if (mkt)
            c = 1'b1;
        else if (side == SIDE_BID)
            c = (limit >= lvl);
        else
            c = (limit <= lvl);
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/lobm_order_if.sv
`default_nettype none
interface lobm_order_if;
    import lobm_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    order_id;
    logic               side;
    logic               order_kind;
    logic [1:0]         time_in_force;
    logic [PRICE_W-1:0] price_tick;
    logic [QTY_W-1:0]   quantity;

    modport source (output valid, order_id, side, order_kind, time_in_force,
                    price_tick, quantity, input ready);
    modport sink (input valid, order_id, side, order_kind, time_in_force,
                  price_tick, quantity, output ready);
endinterface
`default_nettype wire

### hw/rtl/lobm_result_if.sv
`default_nettype none
interface lobm_result_if;
    import lobm_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    aggressor_id;
    logic [ID_W-1:0]    resting_id;
    logic [PRICE_W-1:0] trade_price;
    logic [QTY_W-1:0]   trade_qty;
    logic               last;
    logic [1:0]         status;
    logic [PRICE_W-1:0] best_bid;
    logic               best_bid_valid;
    logic [PRICE_W-1:0] best_ask;
    logic               best_ask_valid;
    logic [CNT_W-1:0]   resting_count;

    modport source (output valid, aggressor_id, resting_id, trade_price, trade_qty,
                    last, status, best_bid, best_bid_valid, best_ask, best_ask_valid,
                    resting_count, input ready);
    modport sink (input valid, aggressor_id, resting_id, trade_price, trade_qty,
                  last, status, best_bid, best_bid_valid, best_ask, best_ask_valid,
                  resting_count, output ready);
endinterface
`default_nettype wire

### hw/rtl/lobm_scan.sv
`default_nettype none
module lobm_scan (
    input  wire                                           clk,
    input  wire                                           rst_n,
    input  lobm_pkg::scan_req_t                           req,
    input  wire [1:0][lobm_pkg::PRICE_LEVELS-1:0]         exist,
    output lobm_pkg::scan_rsp_t                           rsp
);
    import lobm_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   side_reg, side_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg, chunk_next;
    logic [CHUNK_BITS-1:0]  lo_reg, lo_next;
    logic                   first_reg, first_next;

    logic [CHUNK_W-1:0]     bits;
    logic [CHUNK_W-1:0]     masked;
    logic [CHUNK_BITS-1:0]  enc;
    logic                   any;
    logic                   at_edge;

    always_comb
    begin
        bits   = exist[side_reg][{chunk_reg, {CHUNK_BITS{1'b0}}} +: CHUNK_W];
        masked = bits;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            // first chunk starts at the requested level
            if (first_reg)
            begin
                if (side_reg == SIDE_ASK && CHUNK_BITS'(i) < lo_reg)
                    masked[i] = 1'b0;
                if (side_reg == SIDE_BID && CHUNK_BITS'(i) > lo_reg)
                    masked[i] = 1'b0;
            end
        end
        enc = '0;
        if (side_reg == SIDE_ASK)
        begin
            for (int i = CHUNK_W - 1; i >= 0; i--)
                if (masked[i])
                    enc = CHUNK_BITS'(i);
        end
        else
        begin
            for (int i = 0; i < CHUNK_W; i++)
                if (masked[i])
                    enc = CHUNK_BITS'(i);
        end
        any     = |masked;
        at_edge = (side_reg == SIDE_ASK) ? (chunk_reg == {CHUNK_IDX_W{1'b1}})
                                         : (chunk_reg == '0);

        rsp.done  = busy_reg && (any || at_edge);
        rsp.found = busy_reg && any;
        rsp.index = {chunk_reg, enc};

        busy_next  = busy_reg;
        side_next  = side_reg;
        chunk_next = chunk_reg;
        lo_next    = lo_reg;
        first_next = first_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            side_next  = req.side;
            chunk_next = req.from[PRICE_W-1:CHUNK_BITS];
            lo_next    = req.from[CHUNK_BITS-1:0];
            first_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (any || at_edge)
                busy_next = 1'b0;
            else
            begin
                first_next = 1'b0;
                chunk_next = (side_reg == SIDE_ASK) ? chunk_reg + 1'b1 : chunk_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            side_reg  <= 1'b0;
            chunk_reg <= '0;
            lo_reg    <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            side_reg  <= side_next;
            chunk_reg <= chunk_next;
            lo_reg    <= lo_next;
            first_reg <= first_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/limit_order_book_matcher_unit.sv
`default_nettype none
// one order at a time: a best level opens with a level read then a head slot read,
// fills are applied in S_M_SLOT, a side is rescanned one 16-level chunk a cycle,
// resting takes S_REST, S_R_POP for a freed slot, S_R_WR; a fill-or-kill check sums
// each crossing level with a rescan; results pass the trade buffer and output register
// a new order is taken while the final result still waits in the output register
// reset empties the book at once: per-level valid bits, fresh slot counter, no sweep
module limit_order_book_matcher_unit (
    input wire           clk,
    input wire           rst_n,
    lobm_order_if.sink   order,
    lobm_result_if.source result
);
    import lobm_pkg::*;

    state_t state_reg, state_next;

    logic [ID_W-1:0]    id_reg, id_next;
    logic               side_reg, side_next;
    logic               mkt_reg, mkt_next;
    logic [1:0]         tif_reg, tif_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [QTY_W-1:0]   qty_reg, qty_next;
    logic [1:0]         status_reg, status_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [TB_AW-1:0]   k_reg, k_next;
    logic [PRICE_W-1:0] fok_p_reg, fok_p_next;
    logic [SUM_W-1:0]   fok_sum_reg, fok_sum_next;
    logic [TOTAL_W-1:0] lt_total_reg, lt_total_next;
    logic [SLOT_W-1:0]  lt_head_reg, lt_head_next;
    logic [SLOT_W-1:0]  lt_tail_reg, lt_tail_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]   fresh_reg, fresh_next;
    logic [CNT_W-1:0]   sp_reg, sp_next;
    logic [1:0][PRICE_W-1:0] top_reg, top_next;
    logic [1:0]         top_valid_reg, top_valid_next;
    logic [1:0][PRICE_LEVELS-1:0] exist_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    // level memory per side and price, slot memories, free stack, trade buffer
    level_t             lv_mem [0:2*PRICE_LEVELS-1];
    slot_t              sd_mem [0:ORDER_SLOTS-1];
    logic [SLOT_W-1:0]  sn_mem [0:ORDER_SLOTS-1];
    logic [SLOT_W-1:0]  fs_mem [0:ORDER_SLOTS-1];
    trade_t             tb_mem [0:MAX_RESULTS-1];

    level_t             lv_rd, lv_wdata;
    logic [LVL_ADDR_W-1:0] lv_raddr, lv_waddr;
    logic               lv_we;
    slot_t              sd_rd, sd_wdata;
    logic [SLOT_W-1:0]  sd_raddr, sd_waddr;
    logic               sd_we;
    logic [SLOT_W-1:0]  sn_rd, sn_wdata, sn_waddr;
    logic               sn_we;
    logic [SLOT_W-1:0]  fs_rd, fs_raddr, fs_waddr, fs_wdata;
    logic               fs_we;
    trade_t             tb_rd, tb_wdata;
    logic [TB_AW-1:0]   tb_raddr, tb_waddr;
    logic               tb_we;
    logic               ex_we, ex_side, ex_val;
    logic [PRICE_W-1:0] ex_idx;

    scan_req_t          scan_req;
    scan_rsp_t          scan_rsp;

    logic               opp;
    logic [PRICE_W-1:0] opp_top;
    logic [QTY_W-1:0]   fill;
    logic [QTY_W-1:0]   rem_new;
    logic [TOTAL_W-1:0] total_new;
    logic [SLOT_W-1:0]  head_new;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   sp_dec;
    logic               rest_ok;
    logic               lvl_exists;
    logic               is_last;

    lobm_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .exist (exist_reg),
        .rsp   (scan_rsp)
    );

    assign opp     = ~side_reg;
    assign opp_top = top_reg[opp];

    always_comb
    begin
        state_next     = state_reg;
        id_next        = id_reg;
        side_next      = side_reg;
        mkt_next       = mkt_reg;
        tif_next       = tif_reg;
        price_next     = price_reg;
        qty_next       = qty_reg;
        status_next    = status_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        fok_p_next     = fok_p_reg;
        fok_sum_next   = fok_sum_reg;
        lt_total_next  = lt_total_reg;
        lt_head_next   = lt_head_reg;
        lt_tail_next   = lt_tail_reg;
        slot_next      = slot_reg;
        fresh_next     = fresh_reg;
        sp_next        = sp_reg;
        top_next       = top_reg;
        top_valid_next = top_valid_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        order.ready = 1'b0;
        lv_raddr = {opp, opp_top};
        lv_we    = 1'b0;
        lv_waddr = {opp, opp_top};
        lv_wdata = '0;
        sd_raddr = lt_head_reg;
        sd_we    = 1'b0;
        sd_waddr = lt_head_reg;
        sd_wdata = '0;
        sn_we    = 1'b0;
        sn_waddr = lv_rd.tail;
        sn_wdata = slot_reg;
        sp_dec   = sp_reg - CNT_W'(1);
        fs_raddr = sp_dec[SLOT_W-1:0];
        fs_we    = 1'b0;
        fs_waddr = sp_reg[SLOT_W-1:0];
        fs_wdata = lt_head_reg;
        tb_raddr = k_reg;
        tb_we    = 1'b0;
        tb_waddr = n_reg[TB_AW-1:0];
        tb_wdata = '0;
        ex_we    = 1'b0;
        ex_side  = opp;
        ex_idx   = opp_top;
        ex_val   = 1'b0;
        scan_req = '0;

        fill      = (sd_rd.rem < qty_reg) ? sd_rd.rem : qty_reg;
        rem_new   = sd_rd.rem - fill;
        total_new = lt_total_reg - TOTAL_W'(fill);
        head_new  = (rem_new == '0) ? sn_rd : lt_head_reg;
        sum_add   = fok_sum_reg + SUM_W'(lv_rd.total);
        rest_ok   = (tif_reg == TIF_GTC || tif_reg == TIF_DTC) && !mkt_reg
                    && (qty_reg != '0);
        lvl_exists = exist_reg[side_reg][price_reg];
        is_last   = (n_reg == '0) || ((CNT_W'(k_reg) + CNT_W'(1)) == n_reg);

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                order.ready = 1'b1;
                if (order.valid)
                begin
                    id_next     = order.order_id;
                    side_next   = order.side;
                    mkt_next    = order.order_kind;
                    tif_next    = order.time_in_force;
                    price_next  = order.price_tick;
                    qty_next    = order.quantity;
                    status_next = STATUS_NOT_RESTED;
                    n_next      = '0;
                    k_next      = '0;
                    state_next  = (order.time_in_force == TIF_FOK) ? S_FOK_START : S_M_TOP;
                end
            end

            S_FOK_START:
            begin
                if (!top_valid_reg[opp])
                begin
                    status_next = STATUS_FOK_KILLED;
                    state_next  = S_EMIT_RD;
                end
                else if (qty_reg == '0)
                    state_next = S_M_TOP;
                else
                begin
                    fok_p_next   = opp_top;
                    fok_sum_next = '0;
                    state_next   = S_FOK_CHK;
                end
            end

            S_FOK_CHK:
            begin
                if (!crosses(side_reg, mkt_reg, price_reg, fok_p_reg))
                begin
                    status_next = STATUS_FOK_KILLED;
                    state_next  = S_EMIT_RD;
                end
                else
                begin
                    lv_raddr   = {opp, fok_p_reg};
                    state_next = S_FOK_ADD;
                end
            end

            S_FOK_ADD:
            begin
                fok_sum_next = sum_add;
                if (sum_add >= SUM_W'(qty_reg))
                    state_next = S_M_TOP;
                else if ((side_reg == SIDE_BID && fok_p_reg == {PRICE_W{1'b1}}) ||
                         (side_reg == SIDE_ASK && fok_p_reg == '0))
                begin
                    status_next = STATUS_FOK_KILLED;
                    state_next  = S_EMIT_RD;
                end
                else
                begin
                    scan_req.start = 1'b1;
                    scan_req.side  = opp;
                    scan_req.from  = (side_reg == SIDE_BID) ? fok_p_reg + PRICE_W'(1)
                                                            : fok_p_reg - PRICE_W'(1);
                    state_next     = S_FOK_SCAN;
                end
            end

            S_FOK_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    if (scan_rsp.found)
                    begin
                        fok_p_next = scan_rsp.index;
                        state_next = S_FOK_CHK;
                    end
                    else
                    begin
                        status_next = STATUS_FOK_KILLED;
                        state_next  = S_EMIT_RD;
                    end
                end
            end

            S_M_TOP:
            begin
                if (qty_reg == '0 || !top_valid_reg[opp] ||
                    !crosses(side_reg, mkt_reg, price_reg, opp_top))
                    state_next = S_REST;
                else
                begin
                    lv_raddr   = {opp, opp_top};
                    state_next = S_M_LVL;
                end
            end

            S_M_LVL:
            begin
                lt_total_next = lv_rd.total;
                lt_head_next  = lv_rd.head;
                lt_tail_next  = lv_rd.tail;
                sd_raddr      = lv_rd.head;
                state_next    = S_M_SLOT;
            end

            S_M_SLOT:
            begin
                if (n_reg < CNT_W'(MAX_RESULTS))
                begin
                    tb_we    = 1'b1;
                    tb_wdata = '{rid: sd_rd.id, price: opp_top, qty: fill};
                    n_next   = n_reg + CNT_W'(1);
                end
                sd_we    = 1'b1;
                sd_wdata = '{id: sd_rd.id, rem: rem_new};
                if (rem_new == '0)
                begin
                    // filled resting order returns its slot to the free stack
                    fs_we   = 1'b1;
                    sp_next = sp_reg + CNT_W'(1);
                end
                lv_we    = 1'b1;
                lv_wdata = '{total: total_new, head: head_new, tail: lt_tail_reg};
                ex_we    = 1'b1;
                ex_val   = (total_new != '0);
                qty_next      = qty_reg - fill;
                lt_total_next = total_new;
                lt_head_next  = head_new;
                sd_raddr      = sn_rd;
                if (total_new == '0)
                begin
                    scan_req.start = 1'b1;
                    scan_req.side  = opp;
                    scan_req.from  = opp_top;
                    state_next     = S_M_SCAN;
                end
                else if (qty_reg == fill)
                    state_next = S_REST;
            end

            S_M_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    top_valid_next[opp] = scan_rsp.found;
                    top_next[opp]       = scan_rsp.index;
                    state_next          = S_M_TOP;
                end
            end

            S_REST:
            begin
                lv_raddr = {side_reg, price_reg};
                if (!rest_ok)
                    state_next = S_EMIT_RD;
                else if (fresh_reg == CNT_W'(ORDER_SLOTS) && sp_reg == '0)
                begin
                    status_next = STATUS_FULL;
                    state_next  = S_EMIT_RD;
                end
                else if (fresh_reg < CNT_W'(ORDER_SLOTS))
                begin
                    slot_next  = fresh_reg[SLOT_W-1:0];
                    fresh_next = fresh_reg + CNT_W'(1);
                    state_next = S_R_WR;
                end
                else
                begin
                    sp_next    = sp_dec;
                    state_next = S_R_POP;
                end
            end

            S_R_POP:
            begin
                slot_next  = fs_rd;
                lv_raddr   = {side_reg, price_reg};
                state_next = S_R_WR;
            end

            S_R_WR:
            begin
                sd_we    = 1'b1;
                sd_waddr = slot_reg;
                sd_wdata = '{id: id_reg, rem: qty_reg};
                sn_we    = lvl_exists;
                lv_we    = 1'b1;
                lv_waddr = {side_reg, price_reg};
                lv_wdata = '{total: lvl_exists ? lv_rd.total + TOTAL_W'(qty_reg)
                                               : TOTAL_W'(qty_reg),
                             head:  lvl_exists ? lv_rd.head : slot_reg,
                             tail:  slot_reg};
                ex_we    = 1'b1;
                ex_side  = side_reg;
                ex_idx   = price_reg;
                ex_val   = 1'b1;
                if (side_reg == SIDE_BID)
                begin
                    if (!top_valid_reg[SIDE_BID] || price_reg > top_reg[SIDE_BID])
                    begin
                        top_next[SIDE_BID]       = price_reg;
                        top_valid_next[SIDE_BID] = 1'b1;
                    end
                end
                else
                begin
                    if (!top_valid_reg[SIDE_ASK] || price_reg < top_reg[SIDE_ASK])
                    begin
                        top_next[SIDE_ASK]       = price_reg;
                        top_valid_next[SIDE_ASK] = 1'b1;
                    end
                end
                status_next = STATUS_RESTED;
                state_next  = S_EMIT_RD;
            end

            S_EMIT_RD:
            begin
                tb_raddr   = k_reg;
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.aggressor_id  = id_reg;
                    out_next.resting_id    = (n_reg == '0) ? '0 : tb_rd.rid;
                    out_next.trade_price   = (n_reg == '0) ? '0 : tb_rd.price;
                    out_next.trade_qty     = (n_reg == '0) ? '0 : tb_rd.qty;
                    out_next.last          = is_last;
                    out_next.status        = status_reg;
                    out_next.best_bid      = top_valid_reg[SIDE_BID] ? top_reg[SIDE_BID] : '0;
                    out_next.best_bid_valid = top_valid_reg[SIDE_BID];
                    out_next.best_ask      = top_valid_reg[SIDE_ASK] ? top_reg[SIDE_ASK] : '0;
                    out_next.best_ask_valid = top_valid_reg[SIDE_ASK];
                    out_next.resting_count = fresh_reg - sp_reg;
                    if (is_last)
                        state_next = S_IDLE;
                    else
                    begin
                        k_next     = k_reg + TB_AW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            fresh_reg     <= '0;
            sp_reg        <= '0;
            top_reg       <= '0;
            top_valid_reg <= '0;
            exist_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            fresh_reg     <= fresh_next;
            sp_reg        <= sp_next;
            top_reg       <= top_next;
            top_valid_reg <= top_valid_next;
            out_valid_reg <= out_valid_next;
            if (ex_we)
                exist_reg[ex_side][ex_idx] <= ex_val;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        side_reg     <= side_next;
        mkt_reg      <= mkt_next;
        tif_reg      <= tif_next;
        price_reg    <= price_next;
        qty_reg      <= qty_next;
        fok_p_reg    <= fok_p_next;
        fok_sum_reg  <= fok_sum_next;
        lt_total_reg <= lt_total_next;
        lt_head_reg  <= lt_head_next;
        lt_tail_reg  <= lt_tail_next;
        slot_reg     <= slot_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (lv_we)
            lv_mem[lv_waddr] <= lv_wdata;
        lv_rd <= lv_mem[lv_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sd_we)
            sd_mem[sd_waddr] <= sd_wdata;
        sd_rd <= sd_mem[sd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sn_we)
            sn_mem[sn_waddr] <= sn_wdata;
        sn_rd <= sn_mem[sd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
            fs_mem[fs_waddr] <= fs_wdata;
        fs_rd <= fs_mem[fs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tb_we)
            tb_mem[tb_waddr] <= tb_wdata;
        tb_rd <= tb_mem[tb_raddr];
    end

    assign result.valid          = out_valid_reg;
    assign result.aggressor_id   = out_reg.aggressor_id;
    assign result.resting_id     = out_reg.resting_id;
    assign result.trade_price    = out_reg.trade_price;
    assign result.trade_qty      = out_reg.trade_qty;
    assign result.last           = out_reg.last;
    assign result.status         = out_reg.status;
    assign result.best_bid       = out_reg.best_bid;
    assign result.best_bid_valid = out_reg.best_bid_valid;
    assign result.best_ask       = out_reg.best_ask;
    assign result.best_ask_valid = out_reg.best_ask_valid;
    assign result.resting_count  = out_reg.resting_count;

    // free stack never holds more slots than were handed out
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= fresh_reg)
        else $error("free stack deeper than allocated slots");

    // a fill always has nonzero quantity, so a zero-quantity result stands alone
    a_no_trade_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.trade_qty == '0) |-> result.last)
        else $error("zero-quantity result not last");

    // matching only ever works on the live best level of the opposite side
    a_match_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_M_SLOT) |-> (top_valid_reg[opp] && exist_reg[opp][opp_top]))
        else $error("fill against an empty level");

endmodule
`default_nettype wire
